>>> rtl/klk_pkg.sv
`default_nettype none

package klk_pkg;

	localparam int MaxDigitsDef    = 16;
	localparam int HistorySlotsDef = 3;

	localparam logic [3:0]  MaxAttemptsRst  = 4'd3;
	localparam logic [15:0] LockoutTicksRst = 16'd60000;

	localparam logic [4:0] KEY_NONE = 5'd0;
	localparam logic [4:0] KEY_OK   = 5'd4;
	localparam logic [4:0] KEY_LOCK = 5'd8;
	localparam logic [4:0] KEY_LAST = 5'd16;

	localparam logic       CMD_KEY  = 1'b0;
	localparam logic       CMD_TICK = 1'b1;

	localparam logic       REG_MAX_ATTEMPTS  = 1'b0;
	localparam logic       REG_LOCKOUT_TICKS = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_SET     = 2'd1,
		MODE_LOCKED  = 2'd2,
		MODE_LOCKOUT = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		EV_NONE         = 4'd0,
		EV_KEYPRESS     = 4'd1,
		EV_STORED       = 4'd2,
		EV_REJECTED     = 4'd3,
		EV_LOCKOUT      = 4'd4,
		EV_UNLOCKED     = 4'd5,
		EV_NO_CODE      = 4'd6,
		EV_LOCKOUT_OVER = 4'd7,
		EV_LOCKED       = 4'd8
	} event_t;

	typedef struct packed {
		logic       command;
		logic [4:0] key_code;
	} in_item_t;

	typedef struct packed {
		logic [3:0] event_res;
		logic [1:0] mode;
		logic [3:0] failed_attempts;
		logic       code_set_flag;
		logic [4:0] entry_length;
	} out_item_t;

	typedef struct packed {
		logic       is_digit;
		logic [3:0] value;
	} key_digit_t;

	// keypad layout: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
	function automatic key_digit_t digit_of_key(input logic [4:0] key);
		key_digit_t d;
		d = '{is_digit: 1'b1, value: 4'd0};
		case (key)
			5'd1:    d.value = 4'd1;
			5'd2:    d.value = 4'd2;
			5'd3:    d.value = 4'd3;
			5'd5:    d.value = 4'd4;
			5'd6:    d.value = 4'd5;
			5'd7:    d.value = 4'd6;
			5'd9:    d.value = 4'd7;
			5'd10:   d.value = 4'd8;
			5'd11:   d.value = 4'd9;
			5'd14:   d.value = 4'd0;
			default: d.is_digit = 1'b0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

>>> rtl/keypad_code_lock_controller.sv
// Each accepted item's result is captured in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; the input is held only while a result waits
// unread in the output register.
// Reset (arst_n low, asynchronous): idle mode, empty entry, empty history,
// no code stored, counters cleared, max_attempts 3, lockout_ticks 60000.
`default_nettype none

module keypad_code_lock_controller #(
	parameter int MAX_DIGITS    = klk_pkg::MaxDigitsDef,
	parameter int HISTORY_SLOTS = klk_pkg::HistorySlotsDef
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  klk_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output klk_pkg::out_item_t  out_data,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire  [15:0]         cfg_data
);
	import klk_pkg::*;

	localparam int CODE_W = 4 * MAX_DIGITS;
	localparam int DIG_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int SLOT_W = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
	localparam logic [4:0]        MaxCount = 5'(MAX_DIGITS);
	localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(HISTORY_SLOTS - 1);

	logic [3:0]  max_attempts_q;
	logic [15:0] lockout_ticks_q;

	mode_t              mode_q, mode_d;
	logic [CODE_W-1:0]  entry_q, entry_d;
	logic [4:0]         count_q, count_d;
	logic [CODE_W-1:0]  hist_code_q [HISTORY_SLOTS];
	logic [4:0]         hist_len_q  [HISTORY_SLOTS];
	logic [SLOT_W-1:0]  cur_slot_q, next_slot_q;
	logic               code_set_q, code_set_d;
	logic [3:0]         attempt_q, attempt_d;
	logic [15:0]        lockout_q, lockout_d;

	logic       accept;
	logic       key_ev, tick_ev, key_ok, key_lock;
	key_digit_t dig;
	logic       in_hist, cur_match, store_ok;
	logic [3:0] attempt_inc;
	logic       trip;
	logic       tick_end;
	logic       do_store, do_clear, do_add;
	event_t     ev;
	logic [HISTORY_SLOTS-1:0] slot_hit;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	// decode
	always_comb begin
		tick_ev  = (in_data.command == CMD_TICK);
		key_ev   = (in_data.command == CMD_KEY) && (in_data.key_code != KEY_NONE)
			&& (in_data.key_code <= KEY_LAST);
		key_ok   = key_ev && (in_data.key_code == KEY_OK);
		key_lock = key_ev && (in_data.key_code == KEY_LOCK);
		dig      = digit_of_key(in_data.key_code);
		for (int s = 0; s < HISTORY_SLOTS; s++) begin
			slot_hit[s] = (hist_len_q[s] == count_q) && (hist_code_q[s] == entry_q);
		end
		in_hist     = |slot_hit;
		cur_match   = slot_hit[cur_slot_q];
		store_ok    = (count_q != 5'd0) && !in_hist;
		attempt_inc = (attempt_q == 4'hF) ? attempt_q : attempt_q + 4'd1;
		trip        = (attempt_inc >= max_attempts_q);
		tick_end    = (lockout_q <= 16'd1);
	end

	// next mode
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			MODE_IDLE: begin
				if (key_ok)
					mode_d = MODE_SET;
				else if (key_lock && code_set_q)
					mode_d = MODE_LOCKED;
			end
			MODE_SET: begin
				if (key_ok && store_ok)
					mode_d = MODE_IDLE;
			end
			MODE_LOCKED: begin
				if (key_ok)
					mode_d = cur_match ? MODE_IDLE : (trip ? MODE_LOCKOUT : MODE_LOCKED);
			end
			MODE_LOCKOUT: begin
				if (tick_ev && tick_end)
					mode_d = MODE_LOCKED;
			end
			default: mode_d = MODE_IDLE;
		endcase
	end

	// event and datapath control
	always_comb begin
		ev       = EV_NONE;
		do_store = 1'b0;
		do_clear = 1'b0;
		do_add   = 1'b0;
		case (mode_q)
			MODE_IDLE: begin
				if (key_ok) begin
					ev       = EV_KEYPRESS;
					do_clear = 1'b1;
				end else if (key_lock) begin
					ev       = code_set_q ? EV_LOCKED : EV_NO_CODE;
					do_clear = code_set_q;
				end
			end
			MODE_SET: begin
				if (key_ok) begin
					ev       = store_ok ? EV_STORED : EV_REJECTED;
					do_store = store_ok;
					do_clear = 1'b1;
				end else if (key_ev && dig.is_digit) begin
					ev     = EV_KEYPRESS;
					do_add = 1'b1;
				end
			end
			MODE_LOCKED: begin
				if (key_ok) begin
					ev       = cur_match ? EV_UNLOCKED : (trip ? EV_LOCKOUT : EV_REJECTED);
					do_clear = 1'b1;
				end else if (key_ev && dig.is_digit) begin
					ev     = EV_KEYPRESS;
					do_add = 1'b1;
				end
			end
			MODE_LOCKOUT: begin
				if (tick_ev && tick_end) begin
					ev       = EV_LOCKOUT_OVER;
					do_clear = 1'b1;
				end
			end
			default: ev = EV_NONE;
		endcase
	end

	always_comb begin
		entry_d    = entry_q;
		count_d    = count_q;
		code_set_d = code_set_q;
		attempt_d  = attempt_q;
		lockout_d  = lockout_q;
		if (do_clear) begin
			entry_d = '0;
			count_d = 5'd0;
		end else if (do_add && (count_q < MaxCount)) begin
			entry_d[4*count_q[DIG_W-1:0] +: 4] = dig.value;
			count_d = count_q + 5'd1;
		end
		if (do_store)
			code_set_d = 1'b1;
		if (mode_q == MODE_IDLE && key_lock && code_set_q)
			attempt_d = 4'd0;
		if (mode_q == MODE_LOCKED && key_ok) begin
			if (cur_match) begin
				code_set_d = 1'b0;
			end else if (trip) begin
				attempt_d = 4'd0;
				lockout_d = lockout_ticks_q;
			end else begin
				attempt_d = attempt_inc;
			end
		end
		if (mode_q == MODE_LOCKOUT && tick_ev)
			lockout_d = tick_end ? 16'd0 : lockout_q - 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q  <= MaxAttemptsRst;
			lockout_ticks_q <= LockoutTicksRst;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_ATTEMPTS:  max_attempts_q  <= cfg_data[3:0];
				REG_LOCKOUT_TICKS: lockout_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			entry_q     <= '0;
			count_q     <= 5'd0;
			cur_slot_q  <= '0;
			next_slot_q <= '0;
			code_set_q  <= 1'b0;
			attempt_q   <= 4'd0;
			lockout_q   <= 16'd0;
			for (int s = 0; s < HISTORY_SLOTS; s++) begin
				hist_code_q[s] <= '0;
				hist_len_q[s]  <= 5'd0;
			end
		end else if (accept) begin
			mode_q     <= mode_d;
			entry_q    <= entry_d;
			count_q    <= count_d;
			code_set_q <= code_set_d;
			attempt_q  <= attempt_d;
			lockout_q  <= lockout_d;
			if (do_store) begin
				cur_slot_q  <= next_slot_q;
				next_slot_q <= (next_slot_q == LastSlot) ? '0 : next_slot_q + SLOT_W'(1);
				hist_code_q[next_slot_q] <= entry_q;
				hist_len_q[next_slot_q]  <= count_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data.event_res       <= ev;
			out_data.mode            <= mode_d;
			out_data.failed_attempts <= attempt_d;
			out_data.code_set_flag   <= code_set_d;
			out_data.entry_length    <= count_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MaxCount)
		else $error("entry count beyond digit limit");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(next_slot_q <= LastSlot) && (cur_slot_q <= LastSlot))
		else $error("history slot out of range");

	a_lockout_attempts: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_LOCKOUT |-> attempt_q == 4'd0)
		else $error("attempt count not cleared in lockout");

	a_store_sets_code: assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_store |=> code_set_q && mode_q == MODE_IDLE && count_q == 5'd0)
		else $error("code store left bad state");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

endmodule

`default_nettype wire

>>> test/tb_keypad_code_lock_controller.sv
`timescale 1ns / 1ps

module tb_keypad_code_lock_controller;
	import klk_pkg::*;

	typedef logic [3:0] digit_q_t [$];

	// key code for each digit value 0..9
	localparam logic [4:0] DigitKey [10] = '{
		5'd14, 5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd10, 5'd11
	};
	localparam logic [4:0] KeyC       = 5'd12;
	localparam logic [4:0] KeyStar    = 5'd13;
	localparam logic [4:0] KeyHash    = 5'd15;
	localparam logic [4:0] KeyD       = 5'd16;
	localparam logic [4:0] KeyRawTop  = 5'd31;
	localparam logic [4:0] StrayKeys [5] = '{KEY_LOCK, KeyC, KeyStar, KeyHash, KeyD};
	localparam logic [3:0] AttemptsTop = 4'd15;

	localparam int Phases = 6;
	localparam int PhaseItems = 320;
	localparam logic [3:0]  PhaseMaxAttempts  [Phases] = '{4'd1, 4'd4, 4'd0, 4'd15, 4'd7, 4'd2};
	localparam logic [15:0] PhaseLockoutTicks [Phases] = '{
		16'd0, 16'd3, 16'd2, 16'd240, 16'd5, 16'd17
	};
	localparam int LongLockout    = 200;
	localparam int PressureAfter  = 300;
	localparam int PressureCycles = 400;
	localparam int ReportCap      = 40;

	class lock_tracker;
		logic [3:0]  max_attempts;
		logic [15:0] lockout_ticks;
		mode_t       mode;
		logic [3:0]  digits [MaxDigitsDef];
		int          n_digits;
		logic [63:0] hist_code [HistorySlotsDef];
		int          hist_len [HistorySlotsDef];
		int          cur_slot;
		int          next_slot;
		bit          code_set;
		logic [3:0]  attempts;
		logic [15:0] lockout_left;
		out_item_t   expected_status [$];
		int          event_count [16];
		int          checked;
		int          mismatches;

		function new();
			max_attempts = MaxAttemptsRst;
			lockout_ticks = LockoutTicksRst;
			mode = MODE_IDLE;
			clear_entry();
			foreach (hist_code[s]) begin
				hist_code[s] = '0;
				hist_len[s] = 0;
			end
			cur_slot = 0;
			next_slot = 0;
			code_set = 1'b0;
			attempts = '0;
			lockout_left = '0;
			foreach (event_count[e]) event_count[e] = 0;
			checked = 0;
			mismatches = 0;
		endfunction

		function void set_reg(input logic idx, input logic [15:0] value);
			if (idx == REG_MAX_ATTEMPTS)
				max_attempts = value[3:0];
			else
				lockout_ticks = value;
		endfunction

		function void clear_entry();
			foreach (digits[i]) digits[i] = '0;
			n_digits = 0;
		endfunction

		function logic [63:0] entry_word();
			logic [63:0] w;
			w = '0;
			for (int i = 0; i < MaxDigitsDef; i++) w[4*i +: 4] = digits[i];
			return w;
		endfunction

		function bit entry_equals(input int slot);
			return hist_len[slot] == n_digits && hist_code[slot] == entry_word();
		endfunction

		function bit entry_in_history();
			for (int s = 0; s < HistorySlotsDef; s++)
				if (entry_equals(s)) return 1'b1;
			return 1'b0;
		endfunction

		function bit key_digit(input logic [4:0] key, output logic [3:0] d);
			d = '0;
			for (int i = 0; i < 10; i++) begin
				if (DigitKey[i] == key) begin
					d = 4'(i);
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function event_t add_digit(input logic [4:0] key);
			logic [3:0] d;
			if (!key_digit(key, d)) return EV_NONE;
			if (n_digits < MaxDigitsDef) begin
				digits[n_digits] = d;
				n_digits++;
			end
			return EV_KEYPRESS;
		endfunction

		function void note_item(input in_item_t it);
			event_t     ev;
			logic [4:0] key;
			out_item_t  want;
			ev = EV_NONE;
			key = (it.key_code > KEY_LAST) ? KEY_NONE : it.key_code;
			if (it.command == CMD_TICK) begin
				if (mode == MODE_LOCKOUT) begin
					if (lockout_left <= 16'd1) begin
						lockout_left = '0;
						mode = MODE_LOCKED;
						clear_entry();
						ev = EV_LOCKOUT_OVER;
					end else begin
						lockout_left--;
					end
				end
			end else if (key != KEY_NONE) begin
				case (mode)
					MODE_IDLE: begin
						if (key == KEY_OK) begin
							mode = MODE_SET;
							clear_entry();
							ev = EV_KEYPRESS;
						end else if (key == KEY_LOCK) begin
							if (code_set) begin
								mode = MODE_LOCKED;
								clear_entry();
								attempts = '0;
								ev = EV_LOCKED;
							end else begin
								ev = EV_NO_CODE;
							end
						end
					end
					MODE_SET: begin
						if (key == KEY_OK) begin
							if (n_digits > 0 && !entry_in_history()) begin
								cur_slot = next_slot;
								next_slot = (next_slot + 1 >= HistorySlotsDef) ? 0 : next_slot + 1;
								hist_code[cur_slot] = entry_word();
								hist_len[cur_slot] = n_digits;
								code_set = 1'b1;
								mode = MODE_IDLE;
								ev = EV_STORED;
							end else begin
								ev = EV_REJECTED;
							end
							clear_entry();
						end else begin
							ev = add_digit(key);
						end
					end
					MODE_LOCKED: begin
						if (key == KEY_OK) begin
							if (entry_equals(cur_slot)) begin
								code_set = 1'b0;
								mode = MODE_IDLE;
								ev = EV_UNLOCKED;
							end else begin
								if (attempts < AttemptsTop) attempts++;
								if (attempts >= max_attempts) begin
									attempts = '0;
									mode = MODE_LOCKOUT;
									lockout_left = lockout_ticks;
									ev = EV_LOCKOUT;
								end else begin
									ev = EV_REJECTED;
								end
							end
							clear_entry();
						end else begin
							ev = add_digit(key);
						end
					end
					default: ;
				endcase
			end
			event_count[ev]++;
			want.event_res = ev;
			want.mode = mode;
			want.failed_attempts = attempts;
			want.code_set_flag = code_set;
			want.entry_length = 5'(n_digits);
			expected_status.push_back(want);
		endfunction

		task report(input string what);
			mismatches++;
			if (mismatches <= ReportCap) $display("ERROR at %0t: %s", $time, what);
		endtask

		task cmp_field(input string name, input logic [4:0] got_v, input logic [4:0] want_v);
			if (got_v !== want_v)
				report($sformatf("result %0d %s: got %0d, expected %0d",
					checked, name, got_v, want_v));
		endtask

		task check_status(input out_item_t got);
			out_item_t want;
			checked++;
			if (expected_status.size() == 0) begin
				report($sformatf("result %0d arrived with nothing outstanding", checked));
				return;
			end
			want = expected_status.pop_front();
			cmp_field("event_res", 5'(got.event_res), 5'(want.event_res));
			cmp_field("mode", 5'(got.mode), 5'(want.mode));
			cmp_field("failed_attempts", 5'(got.failed_attempts), 5'(want.failed_attempts));
			cmp_field("code_set_flag", 5'(got.code_set_flag), 5'(want.code_set_flag));
			cmp_field("entry_length", got.entry_length, want.entry_length);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	lock_tracker tracker = new();
	int          sent_count = 0;
	int          counted_items = 0;
	bit          long_lockout_done = 1'b0;

	keypad_code_lock_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) tracker.check_status(out_data);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input logic cmd, input logic [4:0] key, input bit fast = 1'b0);
		int       gap;
		in_item_t it;
		gap = fast ? 0 : pick_gap();
		it.command = cmd;
		it.key_code = key;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		if (tracker.mode != MODE_LOCKOUT) counted_items++;
		tracker.note_item(it);
		sent_count++;
	endtask

	task automatic send_random_item();
		send_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, KeyRawTop)));
	endtask

	// items that set and locked modes ignore
	task automatic send_stray();
		case ($urandom_range(0, 3))
			0: send_item(CMD_KEY, StrayKeys[$urandom_range(0, 4)]);
			1: send_item(CMD_KEY, KEY_NONE);
			2: send_item(CMD_KEY, 5'($urandom_range(KEY_LAST + 1, KeyRawTop)));
			default: send_item(CMD_TICK, 5'($urandom_range(0, KeyRawTop)));
		endcase
	endtask

	task automatic enter_code(input digit_q_t ds);
		foreach (ds[i]) begin
			if ($urandom_range(0, 9) == 0) send_stray();
			send_item(CMD_KEY, DigitKey[ds[i]]);
		end
	endtask

	function automatic digit_q_t make_code(input int len);
		digit_q_t q;
		repeat (len) q.push_back(4'($urandom_range(0, 9)));
		return q;
	endfunction

	function automatic digit_q_t slot_code(input int slot);
		digit_q_t q;
		for (int i = 0; i < tracker.hist_len[slot]; i++)
			q.push_back(tracker.hist_code[slot][4*i +: 4]);
		return q;
	endfunction

	task automatic write_reg(input logic idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, value);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (tracker.expected_status.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic random_step();
		int       r;
		digit_q_t ds;
		r = $urandom_range(0, 99);
		case (tracker.mode)
			MODE_IDLE: begin
				if (r < 10) send_random_item();
				else if (r < 50) send_item(CMD_KEY, KEY_OK);
				else send_item(CMD_KEY, KEY_LOCK);
			end
			MODE_SET: begin
				if (r < 5) begin
					send_random_item();
					return;
				end
				if (r < 15) ds = {};
				else if (r < 40) ds = slot_code($urandom_range(0, HistorySlotsDef - 1));
				else if (r < 50) ds = make_code($urandom_range(MaxDigitsDef + 1, MaxDigitsDef + 4));
				else if (r < 55) ds = make_code(MaxDigitsDef);
				else ds = make_code($urandom_range(1, 6));
				enter_code(ds);
				send_item(CMD_KEY, KEY_OK);
			end
			MODE_LOCKED: begin
				if (r < 5) begin
					send_random_item();
					return;
				end
				ds = slot_code(tracker.cur_slot);
				if (r < 50) begin
					if (ds.size() == MaxDigitsDef && $urandom_range(0, 1))
						ds = {ds, make_code($urandom_range(1, 3))};
				end else if (r < 60) begin
					ds = slot_code($urandom_range(0, HistorySlotsDef - 1));
				end else if (r < 68) begin
					if (ds.size() > 0) void'(ds.pop_back());
				end else if (r < 80 &&
						(tracker.lockout_ticks < LongLockout || !long_lockout_done)) begin
					// wrong codes until the lockout starts
					if (tracker.lockout_ticks >= LongLockout) long_lockout_done = 1'b1;
					while (tracker.mode == MODE_LOCKED) begin
						enter_code(make_code(ds.size() + 1));
						send_item(CMD_KEY, KEY_OK);
					end
					return;
				end else begin
					ds = make_code($urandom_range(1, 6));
				end
				enter_code(ds);
				send_item(CMD_KEY, KEY_OK);
			end
			default: begin
				if (r < 10)
					send_item(CMD_KEY, 5'($urandom_range(0, KeyRawTop)));
				else
					send_item(CMD_TICK, 5'($urandom_range(0, KeyRawTop)),
						tracker.lockout_left > 16'd20);
			end
		endcase
	endtask

	initial begin : receiver
		bit ready;
		int len;
		bit held_off;
		held_off = 1'b0;
		forever begin
			if (!held_off && tracker.checked >= PressureAfter) begin
				held_off = 1'b1;
				ready = 1'b0;
				len = PressureCycles;
			end else if ($urandom_range(0, 3) != 0) begin
				ready = 1'b1;
				len = $urandom_range(1, 30);
			end else begin
				ready = 1'b0;
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
			end
			out_ready <= ready;
			repeat (len) @(posedge clk);
		end
	end

	initial begin : stimulus
		int          base;
		logic [15:0] v;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MAX_ATTEMPTS;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(REG_MAX_ATTEMPTS, 16'd2);
		write_reg(REG_LOCKOUT_TICKS, 16'd1);
		send_item(CMD_TICK, KeyRawTop);
		send_item(CMD_KEY, KEY_NONE);
		send_item(CMD_KEY, KEY_LAST + 5'd1);
		send_item(CMD_KEY, KeyRawTop);
		send_item(CMD_KEY, KEY_LOCK);
		send_item(CMD_KEY, KeyC);
		send_item(CMD_KEY, KEY_OK);
		send_item(CMD_KEY, KEY_OK);
		send_item(CMD_KEY, KeyD);
		send_item(CMD_KEY, DigitKey[0]);
		send_item(CMD_KEY, DigitKey[1]);
		send_item(CMD_KEY, DigitKey[9]);
		send_item(CMD_KEY, KEY_OK);
		send_item(CMD_KEY, KEY_LOCK);
		send_item(CMD_KEY, KeyHash);
		send_item(CMD_KEY, DigitKey[2]);
		send_item(CMD_KEY, KEY_OK);
		send_item(CMD_KEY, KEY_OK);
		send_item(CMD_KEY, DigitKey[1]);
		send_item(CMD_TICK, KEY_NONE);
		send_item(CMD_KEY, DigitKey[0]);
		send_item(CMD_KEY, DigitKey[1]);
		send_item(CMD_KEY, DigitKey[9]);
		send_item(CMD_KEY, KEY_OK);
		send_item(CMD_KEY, KEY_OK);
		enter_code('{4'd0, 4'd1, 4'd9});
		send_item(CMD_KEY, KEY_OK);
		in_valid <= 1'b0;
		wait_drained();

		for (int p = 0; p < Phases; p++) begin
			v = 16'($urandom);
			v[3:0] = PhaseMaxAttempts[p];
			write_reg(REG_MAX_ATTEMPTS, v);
			write_reg(REG_LOCKOUT_TICKS, PhaseLockoutTicks[p]);
			base = counted_items;
			while (counted_items - base < PhaseItems) random_step();
			in_valid <= 1'b0;
			wait_drained();
		end
		repeat (4) @(posedge clk);

		$display("Checked %0d results from %0d items over %0d register settings.",
			tracker.checked, sent_count, Phases + 1);
		$display("Codes stored %0d, rejected %0d, unlocks %0d, lockouts %0d begun / %0d ended.",
			tracker.event_count[EV_STORED], tracker.event_count[EV_REJECTED],
			tracker.event_count[EV_UNLOCKED], tracker.event_count[EV_LOCKOUT],
			tracker.event_count[EV_LOCKOUT_OVER]);
		if (tracker.mismatches == 0 && tracker.expected_status.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		#(100_000_000);
		$display("Timed out");
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
rtl/klk_pkg.sv
rtl/keypad_code_lock_controller.sv
test/tb_keypad_code_lock_controller.sv
